@@ rtl/assert_macros.svh @@
// Assertion macros shared by the framebuffer RTL; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define PFPW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfpw: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define PFPW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfpw: next-cycle check failed");

`else

`define PFPW_ASSERT_IMP(lbl, ante, cons)
`define PFPW_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ rtl/pfpw_pkg.sv @@
// Shared types and constants of the page framebuffer pixel writer.
`timescale 1ns / 1ps

package pfpw_pkg;

  // Action codes carried by an input beat
  typedef enum logic [2:0] {
    ACT_VWRITE = 3'd0,
    ACT_HWRITE = 3'd1,
    ACT_FILL   = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_SWEEP = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RMW   = 5'b00100,
    ST_LOOK  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // One read-modify-write step: which bits to touch and their new values
  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] bits;
  } step_t;

  // Byte steps per write action
  localparam logic [3:0] VSTEPS = 4'd2;
  localparam logic [3:0] HSTEPS = 4'd8;

endpackage

@@ rtl/pfpw_if.sv @@
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps

interface pfpw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] col_x;
  logic [7:0] row_y;
  logic [7:0] pixel_byte;

  modport source (output valid, action, col_x, row_y, pixel_byte, input ready);
  modport sink   (input valid, action, col_x, row_y, pixel_byte, output ready);
endinterface

interface pfpw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;

  modport source (output valid, read_byte, input ready);
  modport sink   (input valid, read_byte, output ready);
endinterface

@@ rtl/page_framebuffer_pixel_writer_core.sv @@
// Top level of the page-organised monochrome framebuffer pixel writer.
// The frame lives in one RAM of 8-pixel vertical bytes addressed {page, column}.
// An input beat is taken only when the previous action is finished. Each byte
// step of a vertical or horizontal write is a pipelined read-modify-write
// through the RAM's single read and write ports (2 and 8 steps). Fill and clear
// sweep the whole RAM, one entry per cycle. After reset the same sweep zeroes
// the RAM before the first beat is accepted. The result register lets the next
// beat in while a result still waits for the sink.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module page_framebuffer_pixel_writer_core #(
  parameter int WIDTH_PX  = 128,
  parameter int HEIGHT_PX = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  pfpw_in_if.sink           in_ch,
  pfpw_out_if.source        out_ch
);

  localparam int PAGES = (HEIGHT_PX + 7) / 8;
  localparam int CW    = $clog2(WIDTH_PX);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int AW    = PW + CW;
  localparam int DEPTH = 1 << AW;

  pfpw_pkg::state_t state_r, state_nxt;
  logic             item_r, item_nxt;
  logic [7:0]       x_r, x_nxt;
  logic [7:0]       y_r, y_nxt;
  logic [7:0]       d_r, d_nxt;
  logic             vert_r, vert_nxt;
  logic [3:0]       k_r, k_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic [AW-1:0]    sweep_r, sweep_nxt;
  logic [7:0]       fill_r, fill_nxt;
  logic             wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]    wr_addr_r, wr_addr_nxt;
  logic [7:0]       wr_mask_r, wr_mask_nxt;
  logic [7:0]       wr_bits_r, wr_bits_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;

  logic             accept_w;
  logic             issue_w;
  logic [AW-1:0]    step_addr_w;
  pfpw_pkg::step_t  step_op_w;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_q;

  // Step generator for the current write byte
  pfpw_step #(
    .WIDTH_PX  (WIDTH_PX),
    .HEIGHT_PX (HEIGHT_PX)
  ) u_step (
    .vert       (vert_r),
    .col_x      (x_r),
    .row_y      (y_r),
    .pixel_byte (d_r),
    .step       (k_r[2:0]),
    .addr       (step_addr_w),
    .op         (step_op_w)
  );

  // Frame store
  pfpw_ram #(
    .DATA_W (8),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign in_ch.ready      = (state_r == pfpw_pkg::ST_IDLE);
  assign accept_w         = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_byte = out_byte_r;

  // More byte steps left to read in this write
  assign issue_w = (state_r == pfpw_pkg::ST_RMW) &&
                   (k_r != (vert_r ? pfpw_pkg::VSTEPS : pfpw_pkg::HSTEPS));

  // RAM port steering: sweep writes, or the write half of a pending RMW
  always_comb begin
    if (state_r == pfpw_pkg::ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_r;
      ram_wdata = fill_r;
    end else begin
      ram_we    = wr_pend_r && (wr_mask_r != 8'h00);
      ram_waddr = wr_addr_r;
      ram_wdata = (ram_q & ~wr_mask_r) | (wr_bits_r & wr_mask_r);
    end
  end

  assign ram_re    = issue_w || (state_r == pfpw_pkg::ST_LOOK);
  assign ram_raddr = (state_r == pfpw_pkg::ST_LOOK) ? {y_r[PW-1:0], x_r[CW-1:0]}
                                                    : step_addr_w;

  // Controller
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    d_nxt         = d_r;
    vert_nxt      = vert_r;
    k_nxt         = k_r;
    rd_ok_nxt     = rd_ok_r;
    sweep_nxt     = sweep_r;
    fill_nxt      = fill_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    wr_mask_nxt   = wr_mask_r;
    wr_bits_nxt   = wr_bits_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;

    unique case (state_r)
      pfpw_pkg::ST_SWEEP: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == {AW{1'b1}}) begin
          state_nxt = item_r ? pfpw_pkg::ST_DONE : pfpw_pkg::ST_IDLE;
          item_nxt  = 1'b0;
        end
      end

      pfpw_pkg::ST_IDLE: begin
        if (accept_w) begin
          x_nxt     = in_ch.col_x;
          y_nxt     = in_ch.row_y;
          d_nxt     = in_ch.pixel_byte;
          k_nxt     = 4'd0;
          rd_ok_nxt = 1'b0;
          unique case (pfpw_pkg::action_t'(in_ch.action))
            pfpw_pkg::ACT_VWRITE: begin
              vert_nxt  = 1'b1;
              state_nxt = pfpw_pkg::ST_RMW;
            end
            pfpw_pkg::ACT_HWRITE: begin
              vert_nxt  = 1'b0;
              state_nxt = pfpw_pkg::ST_RMW;
            end
            pfpw_pkg::ACT_FILL: begin
              fill_nxt  = in_ch.pixel_byte;
              sweep_nxt = '0;
              item_nxt  = 1'b1;
              state_nxt = pfpw_pkg::ST_SWEEP;
            end
            pfpw_pkg::ACT_CLEAR: begin
              fill_nxt  = 8'h00;
              sweep_nxt = '0;
              item_nxt  = 1'b1;
              state_nxt = pfpw_pkg::ST_SWEEP;
            end
            pfpw_pkg::ACT_READ: begin
              rd_ok_nxt = ({1'b0, in_ch.col_x} < 9'(WIDTH_PX)) &&
                          ({1'b0, in_ch.row_y} < 9'(PAGES));
              state_nxt = pfpw_pkg::ST_LOOK;
            end
            default: begin
              state_nxt = pfpw_pkg::ST_DONE;
            end
          endcase
        end
      end

      // Read step k while the byte of step k-1 is written back
      pfpw_pkg::ST_RMW: begin
        if (issue_w) begin
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = step_addr_w;
          wr_mask_nxt = step_op_w.mask;
          wr_bits_nxt = step_op_w.bits;
          k_nxt       = k_r + 4'd1;
        end else begin
          state_nxt = pfpw_pkg::ST_DONE;
        end
      end

      pfpw_pkg::ST_LOOK: begin
        state_nxt = pfpw_pkg::ST_DONE;
      end

      // Hand the result to the output register once it is free
      pfpw_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_ok_r ? ram_q : 8'h00;
          state_nxt     = pfpw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pfpw_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfpw_pkg::ST_SWEEP;
      item_r      <= 1'b0;
      sweep_r     <= '0;
      fill_r      <= 8'h00;
      k_r         <= 4'd0;
      rd_ok_r     <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      item_r      <= item_nxt;
      sweep_r     <= sweep_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      rd_ok_r     <= rd_ok_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    d_r        <= d_nxt;
    vert_r     <= vert_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wr_mask_r  <= wr_mask_nxt;
    wr_bits_r  <= wr_bits_nxt;
    out_byte_r <= out_byte_nxt;
  end

  // Checks
  `PFPW_ASSERT_NXT(a_busy_after_accept, accept_w, !in_ch.ready)
  `PFPW_ASSERT_IMP(a_no_write_idle, state_r == pfpw_pkg::ST_IDLE, !ram_we)
  `PFPW_ASSERT_IMP(a_rmw_mask_live, (state_r == pfpw_pkg::ST_RMW) && ram_we, wr_mask_r != 8'h00)
  `PFPW_ASSERT_IMP(a_result_from_done, $rose(out_valid_r), $past(state_r == pfpw_pkg::ST_DONE))
  `PFPW_ASSERT_IMP(a_sweep_blocks_input, state_r == pfpw_pkg::ST_SWEEP, !in_ch.ready)

endmodule

@@ rtl/pfpw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pfpw_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/pfpw_step.sv @@
// Address, mask and pixel bits of one byte step of a vertical or horizontal write.
`timescale 1ns / 1ps

module pfpw_step #(
  parameter int  WIDTH_PX  = 128,
  parameter int  HEIGHT_PX = 64,
  localparam int PAGES     = (HEIGHT_PX + 7) / 8,
  localparam int CW        = $clog2(WIDTH_PX),
  localparam int PW        = (PAGES > 1) ? $clog2(PAGES) : 1,
  localparam int AW        = PW + CW
) (
  input  logic                 vert,
  input  logic [7:0]           col_x,
  input  logic [7:0]           row_y,
  input  logic [7:0]           pixel_byte,
  input  logic [2:0]           step,
  output logic [AW-1:0]        addr,
  output pfpw_pkg::step_t      op
);

  localparam int LAST_ROWS = HEIGHT_PX - 8 * (PAGES - 1);
  localparam logic [7:0] LAST_MASK = 8'((16'd1 << LAST_ROWS) - 16'd1);

  logic [15:0] vmask_w;
  logic [15:0] vbits_w;
  logic [7:0]  hshift_w;
  logic [5:0]  page_w;
  logic [8:0]  col_w;
  logic [7:0]  raw_mask_w;
  logic [7:0]  row_mask_w;
  logic        in_range_w;
  logic [7:0]  mask_w;
  logic [7:0]  bits_w;

  // Vertical byte straddles two pages: low part on page, high part on page+1
  assign vmask_w  = 16'h00FF << row_y[2:0];
  assign vbits_w  = {8'h00, pixel_byte} << row_y[2:0];
  // Horizontal: MSB first, so bit 7-k lands in bit 7 after shifting by k
  assign hshift_w = pixel_byte << step;

  assign page_w = vert ? (6'(row_y[7:3]) + 6'(step[0])) : 6'(row_y[7:3]);
  assign col_w  = vert ? {1'b0, col_x} : ({1'b0, col_x} + 9'(step));

  always_comb begin
    if (vert) begin
      raw_mask_w = step[0] ? vmask_w[15:8] : vmask_w[7:0];
      bits_w     = step[0] ? vbits_w[15:8] : vbits_w[7:0];
    end else begin
      raw_mask_w = 8'h01 << row_y[2:0];
      bits_w     = {8{hshift_w[7]}};
    end
  end

  // Clipping: rows past the panel in the last page, columns and pages past the edge
  assign row_mask_w = (page_w == 6'(PAGES - 1)) ? LAST_MASK : 8'hFF;
  assign in_range_w = (col_w < 9'(WIDTH_PX)) && (page_w < 6'(PAGES));
  assign mask_w     = in_range_w ? (raw_mask_w & row_mask_w) : 8'h00;

  assign op   = '{mask: mask_w, bits: bits_w};
  assign addr = {page_w[PW-1:0], col_w[CW-1:0]};

endmodule
